### hdl/rshlp_pkg.sv
// Shared types, codes and constants of the RS-hash linear-probe table.
package rshlp_pkg;

    localparam int KEY_BYTES = 10;
    localparam int KEY_W     = 8 * KEY_BYTES;
    localparam int VAL_W     = 64;
    localparam int SLOT_W    = 10;
    localparam int CFG_W     = 11;
    localparam int HASH_W    = 32;
    localparam int CNT_W     = 5;

    localparam logic [HASH_W-1:0] RS_A = 32'd63689;
    localparam logic [HASH_W-1:0] RS_B = 32'd378551;

    localparam logic [CFG_W-1:0] SIZE_RESET = 11'd1024;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [15:0]      key_hi;
        logic [63:0]      key_lo;
        logic [VAL_W-1:0] value;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [VAL_W-1:0]  found_value;
        logic [SLOT_W-1:0] slot;
    } t_result;

    // multiplier seen by byte i: RS_A * RS_B^i, wrapped to 32 bits
    typedef logic [HASH_W-1:0] t_mult_tab [KEY_BYTES];

    function automatic t_mult_tab rs_table();
        t_mult_tab t;
        logic [HASH_W-1:0] a;
        a = RS_A;
        for (int i = 0; i < KEY_BYTES; i++) begin
            t[i] = a;
            a = a * RS_B;
        end
        return t;
    endfunction

    localparam t_mult_tab RS_MULT = rs_table();

    typedef struct packed {
        logic       clear_step;
        logic       load;
        logic       hash_step;
        logic       div_step;
        logic       mem_read;
        logic       idx_inc;
        logic       wr_insert;
        logic       clr_used;
        logic       res_en;
        logic       res_hit;
        logic [1:0] res_status;
    } t_dp_cmd;

    typedef struct packed {
        logic       clear_last;
        logic       hash_last;
        logic       div_last;
        logic       in_range;
        logic       used;
        logic       key_match;
        logic [1:0] op;
    } t_dp_status;

endpackage

### hdl/rshlp_ctrl.sv
// Sequencer: clearing pass, hash, modulo, and the probe loop.
module rshlp_ctrl
    import rshlp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  t_dp_status i_stat,
    output t_dp_cmd    o_cmd,
    output logic       o_busy
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_HASH   = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_LOOKUP = 3'd4;
    localparam logic [2:0] S_CHECK  = 3'd5;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_step = 1'b1;
                if (i_stat.clear_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_HASH;
                end
            end
            S_HASH: begin
                o_cmd.hash_step = 1'b1;
                if (i_stat.hash_last) n_state = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) n_state = S_LOOKUP;
            end
            S_LOOKUP: begin
                case (i_stat.op) inside
                    OP_INSERT, OP_FIND: begin
                        if (i_stat.in_range) begin
                            o_cmd.mem_read = 1'b1;
                            n_state        = S_CHECK;
                        end else begin
                            o_cmd.res_en     = 1'b1;
                            o_cmd.res_status = (i_stat.op == OP_INSERT) ? ST_FULL : ST_MISS;
                            n_state          = S_IDLE;
                        end
                    end
                    OP_REMOVE: begin
                        o_cmd.mem_read = 1'b1;
                        n_state        = S_CHECK;
                    end
                    default: begin
                        o_cmd.res_en     = 1'b1;
                        o_cmd.res_status = ST_MISS;
                        n_state          = S_IDLE;
                    end
                endcase
            end
            S_CHECK: begin
                case (i_stat.op)
                    OP_INSERT: begin
                        if (!i_stat.used) begin
                            o_cmd.wr_insert  = 1'b1;
                            o_cmd.res_en     = 1'b1;
                            o_cmd.res_status = ST_OK;
                            n_state          = S_IDLE;
                        end else begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = S_LOOKUP;
                        end
                    end
                    OP_FIND: begin
                        if (i_stat.used && i_stat.key_match) begin
                            o_cmd.res_en     = 1'b1;
                            o_cmd.res_hit    = 1'b1;
                            o_cmd.res_status = ST_OK;
                            n_state          = S_IDLE;
                        end else if (i_stat.used) begin
                            o_cmd.idx_inc = 1'b1;
                            n_state       = S_LOOKUP;
                        end else begin
                            o_cmd.res_en     = 1'b1;
                            o_cmd.res_status = ST_MISS;
                            n_state          = S_IDLE;
                        end
                    end
                    default: begin
                        // remove looks at the home slot only
                        o_cmd.res_en = 1'b1;
                        if (i_stat.used && i_stat.key_match) begin
                            o_cmd.clr_used   = 1'b1;
                            o_cmd.res_status = ST_OK;
                        end else begin
                            o_cmd.res_status = ST_MISS;
                        end
                        n_state = S_IDLE;
                    end
                endcase
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

### hdl/rshlp_dp.sv
// Datapath: request registers, hash and modulo units, slot memories, result register.
module rshlp_dp
    import rshlp_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_req             i_req,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  t_dp_cmd          i_cmd,
    output t_dp_status       o_stat,
    output t_result          o_result,
    output logic             o_result_valid
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = $clog2(DEPTH + 1);

    logic [CFG_W-1:0]  r_cfg_size;
    logic [SW-1:0]     r_size;
    logic [SW-1:0]     n_size;
    logic [1:0]        r_op;
    logic [KEY_W-1:0]  r_key;
    logic [VAL_W-1:0]  r_value;
    logic [HASH_W-1:0] r_h;
    logic [HASH_W-1:0] n_h;
    logic [CNT_W-1:0]  r_cnt;
    logic [SW-1:0]     r_rem;
    logic [SW:0]       n_shift;
    logic [SW-1:0]     n_rem;
    logic [SW-1:0]     r_idx;
    logic [AW-1:0]     w_addr;
    logic [7:0]        w_byte;

    logic [KEY_W+VAL_W-1:0] kv_mem [DEPTH];
    logic                   used_mem [DEPTH];
    logic [KEY_W+VAL_W-1:0] r_kv_q;
    logic                   r_used_q;

    t_result r_result;
    logic    r_res_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_size <= SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_cfg_size <= i_cfg_data;
        end
    end

    // size of zero acts as one, beyond DEPTH clips to DEPTH
    always_comb begin
        if (r_cfg_size == '0) begin
            n_size = SW'(1);
        end else if (32'(r_cfg_size) > 32'(DEPTH)) begin
            n_size = SW'(DEPTH);
        end else begin
            n_size = SW'(r_cfg_size);
        end
    end

    assign w_byte  = r_key[KEY_W-1 - 8*r_cnt -: 8];
    assign n_h     = r_h * RS_MULT[r_cnt[3:0]] + HASH_W'(w_byte);
    assign n_shift = {r_rem, r_h[HASH_W-1]};
    assign n_rem   = (n_shift >= {1'b0, r_size}) ? SW'(n_shift - {1'b0, r_size})
                                                 : n_shift[SW-1:0];
    assign w_addr  = r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_req.operation;
            r_key   <= {i_req.key_hi, i_req.key_lo};
            r_value <= i_req.value;
            r_size  <= n_size;
            r_h     <= '0;
            r_rem   <= '0;
        end else if (i_cmd.hash_step) begin
            r_h <= n_h;
        end else if (i_cmd.div_step) begin
            r_h   <= r_h << 1;
            r_rem <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else begin
            if (i_cmd.load) begin
                r_cnt <= '0;
            end else if (i_cmd.hash_step) begin
                r_cnt <= o_stat.hash_last ? '0 : r_cnt + 1'b1;
            end else if (i_cmd.div_step) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (i_cmd.div_step && o_stat.div_last) begin
                r_idx <= n_rem;
            end else if (i_cmd.clear_step || i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear_step || i_cmd.clr_used) begin
            used_mem[w_addr] <= 1'b0;
        end else if (i_cmd.wr_insert) begin
            used_mem[w_addr] <= 1'b1;
        end
        if (i_cmd.wr_insert) begin
            kv_mem[w_addr] <= {r_key, r_value};
        end
        if (i_cmd.mem_read) begin
            r_used_q <= used_mem[w_addr];
            r_kv_q   <= kv_mem[w_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else begin
            r_res_valid <= i_cmd.res_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.res_en) begin
            r_result.status      <= i_cmd.res_status;
            r_result.found_value <= i_cmd.res_hit ? r_kv_q[VAL_W-1:0] : '0;
            r_result.slot        <= (i_cmd.res_status == ST_OK) ? SLOT_W'(r_idx) : '0;
        end
    end

    assign o_stat.clear_last = (r_idx == SW'(DEPTH - 1));
    assign o_stat.hash_last  = (r_cnt == CNT_W'(KEY_BYTES - 1));
    assign o_stat.div_last   = (r_cnt == CNT_W'(HASH_W - 1));
    assign o_stat.in_range   = (r_idx < r_size);
    assign o_stat.used       = r_used_q;
    assign o_stat.key_match  = (r_kv_q[KEY_W+VAL_W-1:VAL_W] == r_key);
    assign o_stat.op         = r_op;

    assign o_result       = r_result;
    assign o_result_valid = r_res_valid;

endmodule

### hdl/rs_hash_linear_probe_table.sv
// Top level: open-addressing hash table, RS hash of a 10-byte key, linear probing.
// Sequence: a load, a hash step per key byte, a bit-serial modulo step per hash bit,
//   then a LOOKUP and a CHECK state per probed slot; the result is registered last.
// Throughput: one request at a time; the next start is taken in the result cycle.
//   Results are strobes.
// Reset: synchronous, active low; a clearing pass over all DEPTH in-use bits
//   follows, with busy high. Configuration writes are taken at any time.
module rs_hash_linear_probe_table
    import rshlp_pkg::*;
#(
    parameter int DEPTH = 1024
)
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  t_req             i_req,
    output logic             o_result_valid,
    output t_result          o_result,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CFG_W-1:0] i_cfg_data
);

    t_dp_cmd    w_cmd;
    t_dp_status w_stat;

    rshlp_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd),
        .o_busy  (busy)
    );

    rshlp_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req          (i_req),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .o_result       (o_result),
        .o_result_valid (o_result_valid)
    );

    assign o_cfg_ready = 1'b1;

    a_res_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> $past(busy))
        else $error("result without a request in flight");

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_single_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("two results back to back");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_result.status != ST_OK) |->
            (o_result.slot == '0 && o_result.found_value == '0))
        else $error("failed transaction carries nonzero payload");

    a_insert_no_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.wr_insert && w_cmd.clr_used) == 1'b0)
        else $error("insert and remove in the same cycle");

endmodule
